// ===== hdl/sha1_pkg.sv =====
`timescale 1ns / 1ps

package sha1_pkg;

    localparam int BLOCK_WORDS  = 16;
    localparam int WORD_AW      = $clog2(BLOCK_WORDS);
    localparam int ROUNDS       = 80;
    localparam int ROUND_W      = $clog2(ROUNDS);
    localparam int DIGEST_WORDS = 5;
    localparam int FILL_W       = 6;
    localparam int LEN_W        = 64;

    localparam logic [FILL_W-1:0] LEN_LIMIT = 6'd56;
    localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
    localparam logic [7:0]        PAD_BYTE  = 8'h80;
    localparam logic [2:0]        IDX_LAST  = 3'd4;

    localparam logic [31:0] SHA_IV [DIGEST_WORDS] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [31:0] K_00 = 32'h5a827999;
    localparam logic [31:0] K_20 = 32'h6ed9eba1;
    localparam logic [31:0] K_40 = 32'h8f1bbcdc;
    localparam logic [31:0] K_60 = 32'hca62c1d6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic reinit;
    } core_ctrl_t;

    typedef struct packed {
        logic                           done;
        logic [ROUND_W-1:0]             round;
        logic [DIGEST_WORDS-1:0][31:0]  chain;
    } core_status_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_UPDATE
    } core_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_BUSY,
        ST_EMIT
    } top_state_t;

    typedef enum logic [1:0] {
        BLK_DATA,
        BLK_PAD,
        BLK_LEN
    } blk_kind_t;

endpackage

// ===== hdl/sha1_stream_hasher.sv =====
`timescale 1ns / 1ps

// channel   ports                          moves
// -------   ----------------------------   ----------------------------------------
// input     s_valid, s_ready, s_data       one message byte and/or end-of-message flag
// output    m_valid, m_ready, m_data       digest words h0..h4, five transfers per message
//
// an ordinary byte leaves s_ready high; the 64th byte of a block starts a compression
// (a fetch state, 80 rounds on the shared round unit, one chain update)
// end of message adds one or two such padded blocks, then five output transfers
// s_ready is low during each compression and, after end of message, until the last
// digest word is taken
// aresetn (synchronous) loads the initial vector and clears the fill and length counts

module sha1_stream_hasher (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sha1_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sha1_pkg::out_item_t m_data
);

    sha1_pkg::top_state_t state_reg, state_next;
    sha1_pkg::blk_kind_t  kind_reg, kind_next;

    logic [sha1_pkg::FILL_W-1:0] fill_reg;
    logic [sha1_pkg::LEN_W-1:0]  len_reg;
    logic [31:0]                 acc_reg;
    logic                        eom_reg;
    logic [2:0]                  idx_reg;

    sha1_pkg::core_ctrl_t   core_ctrl;
    sha1_pkg::core_status_t core_status;

    logic                         in_xfer, out_xfer, byte_in, blk_full, len_fits;
    logic                         ram_we;
    logic [sha1_pkg::WORD_AW-1:0] ram_waddr, ram_raddr, word_j, fill_word;
    logic [31:0]                  ram_wdata, ram_rdata, w_sel, partial_word;
    logic [1:0]                   lane;

    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;
    assign byte_in  = in_xfer && s_data.byte_valid;
    assign blk_full = s_data.byte_valid && (fill_reg == sha1_pkg::FILL_LAST);
    assign len_fits = (fill_reg < sha1_pkg::LEN_LIMIT);
    assign lane     = fill_reg[1:0];

    // a byte completing a word goes to the block buffer merged with the held lanes
    assign ram_we    = byte_in && (lane == 2'd3);
    assign ram_waddr = fill_reg[sha1_pkg::FILL_W-1:2];
    assign ram_wdata = {acc_reg[31:8], s_data.data_byte};

    sha1_ram #(
        .WIDTH(32),
        .DEPTH(sha1_pkg::BLOCK_WORDS)
    ) u_block_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sha1_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (core_ctrl),
        .w_in    (w_sel),
        .status  (core_status)
    );

    // buffered lanes of the open word, then the 0x80 marker, then zeros
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (2'(i) < lane) begin
                partial_word[31-8*i -: 8] = acc_reg[31-8*i -: 8];
            end else if (2'(i) == lane) begin
                partial_word[31-8*i -: 8] = sha1_pkg::PAD_BYTE;
            end else begin
                partial_word[31-8*i -: 8] = 8'h00;
            end
        end
    end

    assign word_j    = core_status.round[sha1_pkg::WORD_AW-1:0];
    assign fill_word = fill_reg[sha1_pkg::FILL_W-1:2];

    always_comb begin
        w_sel = 32'h0;
        unique case (kind_reg)
            sha1_pkg::BLK_DATA: w_sel = ram_rdata;
            sha1_pkg::BLK_PAD: begin
                if (word_j < fill_word) begin
                    w_sel = ram_rdata;
                end else if (word_j == fill_word) begin
                    w_sel = partial_word;
                end else if (len_fits && word_j == 4'd14) begin
                    w_sel = len_reg[63:32];
                end else if (len_fits && word_j == 4'd15) begin
                    w_sel = len_reg[31:0];
                end
            end
            sha1_pkg::BLK_LEN: begin
                if (word_j == 4'd14) begin
                    w_sel = len_reg[63:32];
                end else if (word_j == 4'd15) begin
                    w_sel = len_reg[31:0];
                end
            end
            default: w_sel = 32'h0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            sha1_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (blk_full) begin
                        state_next = sha1_pkg::ST_FETCH;
                        kind_next  = sha1_pkg::BLK_DATA;
                    end else if (s_data.end_of_message) begin
                        state_next = sha1_pkg::ST_FETCH;
                        kind_next  = sha1_pkg::BLK_PAD;
                    end
                end
            end
            sha1_pkg::ST_FETCH: state_next = sha1_pkg::ST_BUSY;
            sha1_pkg::ST_BUSY: begin
                if (core_status.done) begin
                    unique case (kind_reg)
                        sha1_pkg::BLK_DATA: begin
                            if (eom_reg) begin
                                state_next = sha1_pkg::ST_FETCH;
                                kind_next  = sha1_pkg::BLK_PAD;
                            end else begin
                                state_next = sha1_pkg::ST_IDLE;
                            end
                        end
                        sha1_pkg::BLK_PAD: begin
                            if (len_fits) begin
                                state_next = sha1_pkg::ST_EMIT;
                            end else begin
                                state_next = sha1_pkg::ST_FETCH;
                                kind_next  = sha1_pkg::BLK_LEN;
                            end
                        end
                        sha1_pkg::BLK_LEN: state_next = sha1_pkg::ST_EMIT;
                        default: state_next = sha1_pkg::ST_IDLE;
                    endcase
                end
            end
            sha1_pkg::ST_EMIT: begin
                if (m_ready && idx_reg == sha1_pkg::IDX_LAST) begin
                    state_next = sha1_pkg::ST_IDLE;
                end
            end
            default: state_next = sha1_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready          = (state_reg == sha1_pkg::ST_IDLE);
        m_valid          = (state_reg == sha1_pkg::ST_EMIT);
        core_ctrl.start  = (state_reg == sha1_pkg::ST_FETCH);
        core_ctrl.reinit = (state_reg == sha1_pkg::ST_EMIT) && m_ready
                           && (idx_reg == sha1_pkg::IDX_LAST);
        // registered read: word t+1 is requested while round t runs
        if (state_reg == sha1_pkg::ST_FETCH) begin
            ram_raddr = '0;
        end else begin
            ram_raddr = word_j + 4'd1;
        end
        m_data.digest_word = core_status.chain[idx_reg];
        m_data.word_index  = idx_reg;
        m_data.last_word   = (idx_reg == sha1_pkg::IDX_LAST);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha1_pkg::ST_IDLE;
            kind_reg  <= sha1_pkg::BLK_DATA;
            fill_reg  <= '0;
            len_reg   <= '0;
            eom_reg   <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            if (in_xfer) begin
                eom_reg <= s_data.end_of_message;
            end
            if (byte_in) begin
                fill_reg <= fill_reg + 6'd1;
                len_reg  <= len_reg + 64'd8;
            end
            if (out_xfer) begin
                if (idx_reg == sha1_pkg::IDX_LAST) begin
                    idx_reg  <= '0;
                    fill_reg <= '0;
                    len_reg  <= '0;
                end else begin
                    idx_reg <= idx_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_in) begin
            acc_reg[31-8*lane -: 8] <= s_data.data_byte;
        end
    end

    // no input is taken while digest words are offered
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("input accepted during digest output");

    // the final digest transfer returns the block to taking input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_word) |=> s_ready)
        else $error("not ready after final digest word");

    // closing a message always starts a compression (a padded block, or first the data block on a 64th byte)
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.end_of_message) |=> !s_ready)
        else $error("end of message did not start finishing");

    // the round unit finishes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        core_status.done |-> (state_reg == sha1_pkg::ST_BUSY))
        else $error("compression finished outside busy state");

endmodule

// ===== hdl/sha1_ram.sv =====
`timescale 1ns / 1ps

module sha1_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/sha1_core.sv =====
`timescale 1ns / 1ps

module sha1_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sha1_pkg::core_ctrl_t  ctrl,
    input  logic [31:0]           w_in,
    output sha1_pkg::core_status_t status
);

    sha1_pkg::core_state_t state_reg, state_next;

    logic [sha1_pkg::ROUND_W-1:0] round_reg;
    logic [31:0] chain_reg [sha1_pkg::DIGEST_WORDS];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    // message schedule shift line, win_reg[i] holds w[t-16+i]
    logic [31:0] win_reg [sha1_pkg::BLOCK_WORDS];

    logic [31:0] w_exp, w_cur, f_val, k_val, tmp;

    assign w_exp = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w_cur = (round_reg < 7'(sha1_pkg::BLOCK_WORDS)) ? w_in : {w_exp[30:0], w_exp[31]};

    always_comb begin
        priority if (round_reg < 7'd20) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1_pkg::K_00;
        end else if (round_reg < 7'd40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_pkg::K_20;
        end else if (round_reg < 7'd60) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1_pkg::K_40;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_pkg::K_60;
        end
    end

    assign tmp = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + w_cur + k_val;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sha1_pkg::CORE_IDLE: begin
                if (ctrl.start) begin
                    state_next = sha1_pkg::CORE_ROUND;
                end
            end
            sha1_pkg::CORE_ROUND: begin
                if (round_reg == 7'(sha1_pkg::ROUNDS - 1)) begin
                    state_next = sha1_pkg::CORE_UPDATE;
                end
            end
            sha1_pkg::CORE_UPDATE: state_next = sha1_pkg::CORE_IDLE;
            default: state_next = sha1_pkg::CORE_IDLE;
        endcase
    end

    always_comb begin
        status.done  = (state_reg == sha1_pkg::CORE_UPDATE);
        status.round = round_reg;
        for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
            status.chain[i] = chain_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha1_pkg::CORE_IDLE;
            round_reg <= '0;
            for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
                chain_reg[i] <= sha1_pkg::SHA_IV[i];
            end
        end else begin
            state_reg <= state_next;
            if (ctrl.reinit) begin
                for (int i = 0; i < sha1_pkg::DIGEST_WORDS; i++) begin
                    chain_reg[i] <= sha1_pkg::SHA_IV[i];
                end
            end
            if (state_reg == sha1_pkg::CORE_IDLE && ctrl.start) begin
                round_reg <= '0;
            end else if (state_reg == sha1_pkg::CORE_ROUND) begin
                round_reg <= round_reg + 7'd1;
            end
            if (state_reg == sha1_pkg::CORE_UPDATE) begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == sha1_pkg::CORE_IDLE && ctrl.start) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end else if (state_reg == sha1_pkg::CORE_ROUND) begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= tmp;
            for (int i = 0; i < sha1_pkg::BLOCK_WORDS - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[sha1_pkg::BLOCK_WORDS-1] <= w_cur;
        end
    end

endmodule

// ===== tb/sv/sha1_digest_checker.sv =====
`timescale 1ns / 1ps

module sha1_digest_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  sha1_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  sha1_pkg::out_item_t m_data,
    output int                  mismatch_count,
    output int                  words_pending
);

    localparam logic [31:0] HASH_IV [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };
    localparam logic [31:0] ROUND_K0   = 32'h5a827999;
    localparam logic [31:0] ROUND_K1   = 32'h6ed9eba1;
    localparam logic [31:0] ROUND_K2   = 32'h8f1bbcdc;
    localparam logic [31:0] ROUND_K3   = 32'hca62c1d6;
    localparam logic [7:0]  PAD_MARK   = 8'h80;
    localparam int          LEN_START  = 56;
    localparam int          DIGEST_LEN = 5;

    logic [31:0]         chain [5];
    logic [511:0]        msg_block;
    logic [6:0]          fill_bytes;
    logic [63:0]         msg_bits;
    sha1_pkg::out_item_t digest_due [$];

    initial mismatch_count = 0;
    initial words_pending  = 0;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < DIGEST_LEN; i++) chain[i] = HASH_IV[i];
        fill_bytes = '0;
        msg_bits   = '0;
    endfunction

    // 80 rounds over one 512-bit block, byte 0 in the top bits
    function automatic void compress_block(input logic [511:0] blk);
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        for (int t = 0; t < 16; t++) w[t] = blk[511 - 32 * t -: 32];
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int t = 0; t < 80; t++) begin
            if (t >= 16) begin
                w[t % 16] = rotl32(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^
                                   w[(t + 2) % 16] ^ w[t % 16], 1);
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = ROUND_K0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = ROUND_K1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = ROUND_K2;
            end else begin
                f = b ^ c ^ d;
                k = ROUND_K3;
            end
            tmp = rotl32(a, 5) + f + e + w[t % 16] + k;
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = tmp;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    function automatic void close_message();
        logic [511:0]        padded;
        sha1_pkg::out_item_t word;
        int                  n;
        n      = int'(fill_bytes);
        padded = '0;
        for (int i = 0; i < 64; i++) begin
            if (i < n) padded[511 - 8 * i -: 8] = msg_block[511 - 8 * i -: 8];
            else if (i == n) padded[511 - 8 * i -: 8] = PAD_MARK;
        end
        // no room for the length field, spill into a second block
        if (n + 1 > LEN_START) begin
            compress_block(padded);
            padded = '0;
        end
        padded[63:0] = msg_bits;
        compress_block(padded);
        for (int i = 0; i < DIGEST_LEN; i++) begin
            word.digest_word = chain[i];
            word.word_index  = 3'(i);
            word.last_word   = (i == DIGEST_LEN - 1);
            digest_due.push_back(word);
        end
        restart_message();
    endfunction

    always @(posedge aclk) begin
        sha1_pkg::out_item_t want;
        if (!aresetn) begin
            restart_message();
            digest_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (digest_due.size() == 0) begin
                    $display("%0t: digest transfer %h/%0d/%0b with nothing pending", $time,
                             m_data.digest_word, m_data.word_index, m_data.last_word);
                    mismatch_count++;
                end else begin
                    want = digest_due.pop_front();
                    if (m_data.digest_word !== want.digest_word) begin
                        $display("%0t: digest_word expected %h actual %h", $time,
                                 want.digest_word, m_data.digest_word);
                        mismatch_count++;
                    end
                    if (m_data.word_index !== want.word_index) begin
                        $display("%0t: word_index expected %0d actual %0d", $time,
                                 want.word_index, m_data.word_index);
                        mismatch_count++;
                    end
                    if (m_data.last_word !== want.last_word) begin
                        $display("%0t: last_word expected %0b actual %0b", $time,
                                 want.last_word, m_data.last_word);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.byte_valid) begin
                    msg_block[511 - 8 * int'(fill_bytes) -: 8] = s_data.data_byte;
                    fill_bytes = fill_bytes + 7'd1;
                    msg_bits   = msg_bits + 64'd8;
                    if (fill_bytes == 7'd64) begin
                        compress_block(msg_block);
                        fill_bytes = '0;
                    end
                end
                if (s_data.end_of_message) close_message();
            end
        end
        words_pending <= digest_due.size();
    end

endmodule

// ===== tb/sv/tb_sha1_stream_hasher.sv =====
`timescale 1ns / 1ps

module tb_sha1_stream_hasher;

    localparam int MSG_ITEMS       = 500;
    localparam int CYCLE_LIMIT     = 2000000;
    localparam int DRAIN_CYCLES    = 250;
    localparam int HOLD_OFF_CYCLES = 800;
    localparam int HOLD_OFF_AFTER  = 15;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    sha1_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    sha1_pkg::out_item_t m_data;

    int mismatch_count;
    int words_pending;
    int words_taken;
    int items_sent;
    int cycle_count;

    sha1_stream_hasher DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    sha1_digest_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        aresetn <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // mostly back to back, sometimes a few cycles, rarely a long gap
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic offer_item(input logic [7:0] b, input logic bv, input logic eom);
        sha1_pkg::in_item_t item;
        int                 gap;
        gap = idle_span();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        item.data_byte      = b;
        item.byte_valid     = bv;
        item.end_of_message = eom;
        s_data  <= item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (bv || eom) items_sent++;
    endtask

    task automatic send_message(input int len);
        logic eom_on_byte;
        eom_on_byte = (len > 0) && $urandom_range(0, 1);
        for (int i = 0; i < len; i++) begin
            // ignored items in the middle of a message
            if ($urandom_range(0, 9) == 0) offer_item(8'($urandom), 1'b0, 1'b0);
            offer_item(8'($urandom), 1'b1, eom_on_byte && (i == len - 1));
        end
        if (!eom_on_byte) offer_item(8'($urandom), 1'b0, 1'b1);
    endtask

    function automatic int pick_length();
        int edges [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return $urandom_range(0, 12);
        if (r < 85) return edges[$urandom_range(0, 8)];
        return $urandom_range(0, 140);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) words_taken <= 0;
        else if (m_valid && m_ready) words_taken <= words_taken + 1;
    end

    // receiver: random ready pattern with one long hold-off that backs up the input
    initial begin
        bit held_off;
        int span;
        held_off = 1'b0;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!held_off && words_taken >= HOLD_OFF_AFTER) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                held_off = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
                m_ready <= 1'b1;
                span = $urandom_range(50, 150);
            end else if ($urandom_range(0, 1)) begin
                m_ready <= 1'b1;
                span = $urandom_range(1, 8);
            end else begin
                m_ready <= 1'b0;
                span = 1 + idle_span();
            end
            repeat (span) @(posedge aclk);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        items_sent = 0;
        s_valid <= 1'b0;
        s_data  <= '0;
        do @(posedge aclk); while (!aresetn);

        // empty message
        offer_item(8'h5a, 1'b0, 1'b1);
        // idle items change nothing
        offer_item(8'h00, 1'b0, 1'b0);
        offer_item(8'hff, 1'b0, 1'b0);
        // "abc", end flag riding on the last byte
        offer_item(8'h61, 1'b1, 1'b0);
        offer_item(8'h62, 1'b1, 1'b0);
        offer_item(8'h63, 1'b1, 1'b1);
        // byte extremes, then end without a byte
        offer_item(8'h00, 1'b1, 1'b0);
        offer_item(8'hff, 1'b1, 1'b0);
        offer_item(8'ha5, 1'b0, 1'b1);
        // one-byte messages with the end flag
        offer_item(8'hff, 1'b1, 1'b1);
        offer_item(8'h80, 1'b1, 1'b1);

        while (items_sent < MSG_ITEMS) send_message(pick_length());

        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && words_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sha1_pkg.sv
hdl/sha1_ram.sv
hdl/sha1_core.sv
hdl/sha1_stream_hasher.sv
tb/sv/sha1_digest_checker.sv
tb/sv/tb_sha1_stream_hasher.sv
